@@ hw/rtl/vmtr_pkg.sv @@
// ----------------------------------------------------------------------------
// vmtr_pkg: shared types and constants
// Register map, identification values and the stage-1 to stage-2 bundle of
// the virtio-mmio legacy register block.
// ----------------------------------------------------------------------------
package vmtr_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_DONE  = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  // Read-side offsets
  localparam logic [8:0] OFF_MAGIC     = 9'h000;
  localparam logic [8:0] OFF_VERSION   = 9'h004;
  localparam logic [8:0] OFF_DEVICE_ID = 9'h008;
  localparam logic [8:0] OFF_VENDOR_ID = 9'h00C;
  localparam logic [8:0] OFF_FEATURES  = 9'h010;
  localparam logic [8:0] OFF_QUEUE_MAX = 9'h034;
  localparam logic [8:0] OFF_ISR       = 9'h060;
  // Write-side offsets
  localparam logic [8:0] OFF_PAGE_SIZE = 9'h028;
  localparam logic [8:0] OFF_QSIZE     = 9'h038;
  localparam logic [8:0] OFF_ALIGN     = 9'h03C;
  localparam logic [8:0] OFF_FRAME     = 9'h040;
  localparam logic [8:0] OFF_NOTIFY    = 9'h050;
  localparam logic [8:0] OFF_ACK       = 9'h064;
  // Both sides
  localparam logic [8:0] OFF_STATUS    = 9'h070;

  localparam logic [8:0] CFG_BEGIN = 9'h100;
  localparam logic [9:0] CFG_END   = 10'h108;

  localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
  localparam logic [31:0] VERSION_VALUE = 32'd1;
  localparam logic [31:0] DEVICE_ID     = 32'd2;
  localparam logic [31:0] VENDOR_VALUE  = 32'h554D_4551;
  localparam logic [31:0] QUEUE_MAX     = 32'd256;
  localparam logic [31:0] DEFAULT_ALIGN = 32'd4096;

  localparam int unsigned QSUM_W = 38;

  // Everything stage 2 needs to place the rings, plus the result fields
  typedef struct packed {
    logic [63:0]       base;
    logic [35:0]       dlen;
    logic [QSUM_W-1:0] qsum;
    logic [63:0]       amask;
    logic              recomp;
    logic [31:0]       rdata;
    logic              kick;
    logic              irq;
    logic [31:0]       qsize;
  } stage_t;

endpackage

@@ hw/rtl/virtio_mmio_transport_registers.sv @@
// ----------------------------------------------------------------------------
// virtio_mmio_transport_registers: legacy virtio-mmio block device registers
//
// Slave stream: one request per beat. tuser carries the request kind
// (read, write, completion); tdata carries offset, write data and access
// size. Master stream: one response per request, carrying read data, the
// kick flag, the three ring addresses, queue size and the interrupt line.
// Configuration: cfg_we_i loads the 64-bit disk capacity (in sectors) that
// is read back through config space at 0x100..0x107.
//
// Stage 1 registers an accepted request and stage 2 its response for the
// master side. Throughput: one request per cycle while responses are taken;
// stage 1 does the register update and the 32x32 base multiply, stage 2 the
// ring address adds. Stall: if the master side is held off, the response
// stays put, stage 1 may still fill, then tready drops until the response is taken.
// Reset: all registers and ring addresses clear to zero, capacity too,
// and both stages empty.
// ----------------------------------------------------------------------------
module virtio_mmio_transport_registers (
  input  logic         clk_i,
  input  logic         rst_ni,
  // capacity register
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  // request channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // offset[8:0], wdata[40:9], access_size[43:41]
  input  logic [1:0]   s_axis_tuser,  // func[1:0]
  // response channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rdata[31:0], kick[32], desc_ring_addr[96:33], avail_ring_addr[160:97],
  // used_ring_addr[224:161], queue_size[256:225], irq_pending[257]
  output logic [263:0] m_axis_tdata
);
  import vmtr_pkg::*;

  logic   p1_v_q, out_v_q;
  logic   en_out, adv, accept;
  stage_t stage;

  logic [31:0] rdata_q, qsize_q;
  logic        kick_q, irq_q;
  logic [63:0] desc, avail, used;

  // Pipeline control: response register frees up, stage 1 drains into it
  assign en_out        = !out_v_q || m_axis_tready;
  assign adv           = p1_v_q && en_out;
  assign s_axis_tready = !p1_v_q || en_out;
  assign accept        = s_axis_tvalid && s_axis_tready;

  vmtr_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .func_i        (s_axis_tuser),
    .offset_i      (s_axis_tdata[8:0]),
    .wdata_i       (s_axis_tdata[40:9]),
    .access_size_i (s_axis_tdata[43:41]),
    .stage_o       (stage)
  );

  // Ring address registers are also the response payload for the addresses
  vmtr_rings u_rings (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .stage_i (stage),
    .desc_o  (desc),
    .avail_o (avail),
    .used_o  (used)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        p1_v_q <= 1'b1;
      end else if (adv) begin
        p1_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= stage.rdata;
      kick_q  <= stage.kick;
      qsize_q <= stage.qsize;
      irq_q   <= stage.irq;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, irq_q, qsize_q, used, avail, desc, kick_q, rdata_q};

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && p1_v_q))
    else $error("request side blocked without a stalled response");

  a_kick_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && kick_q) |-> (rdata_q == 32'd0))
    else $error("kick response carries read data");

  a_out_follows_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("advanced request did not reach the response register");

endmodule

@@ hw/rtl/vmtr_regs.sv @@
// ----------------------------------------------------------------------------
// vmtr_regs: register file and read path
// Applies one bus request to the 32-bit registers, builds read data and the
// ring base product, and registers the bundle for the ring stage.
// ----------------------------------------------------------------------------
module vmtr_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [63:0]           cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [1:0]            func_i,
  input  logic [8:0]            offset_i,
  input  logic [31:0]           wdata_i,
  input  logic [2:0]            access_size_i,
  output vmtr_pkg::stage_t      stage_o
);
  import vmtr_pkg::*;

  logic [63:0] cap_q;
  logic [31:0] page_q, page_d, qsize_q, qsize_d, align_q, align_d;
  logic [31:0] frame_q, frame_d, status_q, status_d, isr_q, isr_d;
  stage_t      stage_q, stage_d;

  func_e       func;
  logic        is_wr, wr_page, wr_qsize, wr_align, wr_frame;
  logic [2:0]  size_c;
  logic        in_cfg;
  logic [63:0] cap_sh;
  logic [31:0] cfg_rd, rd;

  always_comb begin
    func     = func_e'(func_i);
    is_wr    = (func == FUNC_WRITE);
    wr_page  = is_wr && (offset_i == OFF_PAGE_SIZE);
    wr_qsize = is_wr && (offset_i == OFF_QSIZE);
    wr_align = is_wr && (offset_i == OFF_ALIGN);
    wr_frame = is_wr && (offset_i == OFF_FRAME);

    page_d   = wr_page  ? wdata_i : page_q;
    qsize_d  = wr_qsize ? wdata_i : qsize_q;
    frame_d  = wr_frame ? wdata_i : frame_q;
    align_d  = align_q;
    if (wr_align) begin
      align_d = (wdata_i == 32'd0) ? DEFAULT_ALIGN : wdata_i;
    end
    status_d = (is_wr && offset_i == OFF_STATUS) ? wdata_i : status_q;

    case (func)
      FUNC_WRITE: isr_d = (offset_i == OFF_ACK) ? (isr_q & ~wdata_i) : isr_q;
      FUNC_DONE:  isr_d = isr_q | 32'd1;
      default:    isr_d = isr_q;
    endcase
  end

  // Config space: little-endian capacity bytes, sizes above four clamp to four
  always_comb begin
    size_c = (access_size_i > 3'd4) ? 3'd4 : access_size_i;
    in_cfg = (offset_i >= CFG_BEGIN) &&
             (({1'b0, offset_i} + {7'b0, size_c}) <= CFG_END);
    cap_sh = cap_q >> {offset_i[2:0], 3'b000};
    cfg_rd = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < size_c) begin
        cfg_rd[8*k +: 8] = cap_sh[8*k +: 8];
      end
    end
    if (!in_cfg) begin
      cfg_rd = '0;
    end
  end

  always_comb begin
    case (offset_i)
      OFF_MAGIC:     rd = MAGIC_VALUE;
      OFF_VERSION:   rd = VERSION_VALUE;
      OFF_DEVICE_ID: rd = DEVICE_ID;
      OFF_VENDOR_ID: rd = VENDOR_VALUE;
      OFF_FEATURES:  rd = '0;
      OFF_QUEUE_MAX: rd = QUEUE_MAX;
      OFF_ISR:       rd = isr_q;
      OFF_STATUS:    rd = status_q;
      default:       rd = cfg_rd;
    endcase
  end

  always_comb begin
    stage_d.base   = {32'b0, page_d} * {32'b0, frame_d};
    stage_d.dlen   = {qsize_d, 4'b0000};
    stage_d.qsum   = QSUM_W'(stage_d.dlen) + QSUM_W'({qsize_d, 1'b0}) + QSUM_W'(6);
    // Alignment left at zero from reset gives an all-ones mask
    stage_d.amask  = (align_d == 32'd0) ? '1 : {32'b0, align_d - 32'd1};
    stage_d.recomp = (wr_page || wr_qsize || wr_align || wr_frame) &&
                     (qsize_d != 32'd0) && (page_d != 32'd0);
    stage_d.rdata  = (func == FUNC_READ) ? rd : '0;
    stage_d.kick   = is_wr && (offset_i == OFF_NOTIFY);
    stage_d.irq    = (isr_d != 32'd0);
    stage_d.qsize  = qsize_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= '0;
      page_q   <= '0;
      qsize_q  <= '0;
      align_q  <= '0;
      frame_q  <= '0;
      status_q <= '0;
      isr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        page_q   <= page_d;
        qsize_q  <= qsize_d;
        align_q  <= align_d;
        frame_q  <= frame_d;
        status_q <= status_d;
        isr_q    <= isr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

  a_done_sets_isr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && func_i == FUNC_DONE) |=> isr_q[0])
    else $error("completion did not set isr bit 0");

endmodule

@@ hw/rtl/vmtr_rings.sv @@
// ----------------------------------------------------------------------------
// vmtr_rings: ring address stage
// Places descriptor, available and used rings from the registered base
// product; holds the addresses, which double as the output payload.
// ----------------------------------------------------------------------------
module vmtr_rings (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  vmtr_pkg::stage_t stage_i,
  output logic [63:0]      desc_o,
  output logic [63:0]      avail_o,
  output logic [63:0]      used_o
);
  import vmtr_pkg::*;

  logic [63:0] desc_q, avail_q, used_q;
  logic [63:0] uoff;

  assign uoff = (64'(stage_i.qsum) + stage_i.amask) & ~stage_i.amask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q  <= '0;
      avail_q <= '0;
      used_q  <= '0;
    end else if (adv_i && stage_i.recomp) begin
      desc_q  <= stage_i.base;
      avail_q <= stage_i.base + 64'(stage_i.dlen);
      used_q  <= stage_i.base + uoff;
    end
  end

  assign desc_o  = desc_q;
  assign avail_o = avail_q;
  assign used_o  = used_q;

  a_hold_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(desc_q) && $stable(avail_q) && $stable(used_q))
    else $error("ring addresses moved without an advancing request");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for virtio_mmio_transport_registers
// Drives register requests on the slave stream, models the register file,
// ring address math and capacity config space in the bench, and compares every
// response on the master stream field by field. A short directed table comes
// first, then random traffic in several capacity settings with random idling
// on both streams.
// ----------------------------------------------------------------------------
module tb;
  import vmtr_pkg::*;

  localparam int          PHASE_ITEMS = 475;
  localparam int          CALM_ITEMS  = 150;
  localparam int          N_DIR       = 26;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // identification values as the spec gives them
  localparam logic [31:0] ID_MAGIC  = 32'h7472_6976;
  localparam logic [31:0] ID_VENDOR = 32'h554D_4551;

  typedef struct packed {
    logic [31:0] rdata;
    logic        kick;
    logic [63:0] desc;
    logic [63:0] avail;
    logic [63:0] used;
    logic [31:0] qsize;
    logic        irq;
  } mmio_resp_t;

  typedef struct {
    func_e       kind;
    logic [8:0]  off;
    logic [31:0] wd;
    logic [2:0]  sz;
    bit          known;   // rd below is the expected read data
    logic [31:0] rd;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [63:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata;   // offset[8:0], wdata[40:9], access_size[43:41]
  logic [1:0]   s_axis_tuser;   // func[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // rdata[31:0], kick[32], desc[96:33], avail[160:97], used[224:161],
  // queue_size[256:225], irq_pending[257]
  logic [263:0] m_axis_tdata;

  // register file model
  logic [63:0] cap_sectors = '0;
  logic [31:0] page_sz     = '0;
  logic [31:0] q_size      = '0;
  logic [31:0] q_align     = '0;
  logic [31:0] q_frame     = '0;
  logic [31:0] dev_status  = '0;
  logic [31:0] isr_bits    = '0;
  logic [63:0] desc_addr   = '0;
  logic [63:0] avail_addr  = '0;
  logic [63:0] used_addr   = '0;

  mmio_resp_t  resp_due[$];
  int unsigned err_cnt    = 0;
  int unsigned cyc_cnt    = 0;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0;

  logic [8:0] hot_offs [14] = '{OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID,
                                OFF_FEATURES, OFF_QUEUE_MAX, OFF_ISR, OFF_PAGE_SIZE,
                                OFF_QSIZE, OFF_ALIGN, OFF_FRAME, OFF_NOTIFY, OFF_ACK,
                                OFF_STATUS};

  // Directed table; capacity is 64'h8877665544332211 while it runs
  stim_row_t dir_rows [N_DIR] = '{
    '{FUNC_READ,  OFF_MAGIC,     32'h0,         3'd4, 1'b1, ID_MAGIC},
    '{FUNC_READ,  OFF_VERSION,   32'h0,         3'd4, 1'b1, 32'd1},
    '{FUNC_READ,  OFF_DEVICE_ID, 32'h0,         3'd4, 1'b1, 32'd2},
    '{FUNC_READ,  OFF_VENDOR_ID, 32'h0,         3'd4, 1'b1, ID_VENDOR},
    '{FUNC_READ,  OFF_QUEUE_MAX, 32'h0,         3'd1, 1'b1, 32'd256},
    '{FUNC_READ,  OFF_ISR,       32'h0,         3'd4, 1'b1, 32'd0},
    '{FUNC_DONE,  OFF_MAGIC,     32'h0,         3'd4, 1'b1, 32'd0},
    '{FUNC_READ,  OFF_ISR,       32'h0,         3'd4, 1'b1, 32'd1},
    '{FUNC_WRITE, OFF_ACK,       32'hFFFF_FFFF, 3'd4, 1'b1, 32'd0},
    '{FUNC_WRITE, OFF_PAGE_SIZE, 32'h0000_1000, 3'd4, 1'b0, 32'd0},
    // align still zero from reset: used ring lands on base
    '{FUNC_WRITE, OFF_QSIZE,     32'd8,         3'd4, 1'b0, 32'd0},
    '{FUNC_WRITE, OFF_FRAME,     32'hFFFF_FFFF, 3'd4, 1'b0, 32'd0},
    // zero align becomes 4096
    '{FUNC_WRITE, OFF_ALIGN,     32'h0,         3'd4, 1'b0, 32'd0},
    '{FUNC_WRITE, OFF_ALIGN,     32'd3,         3'd4, 1'b0, 32'd0},
    // zero page size keeps the old rings
    '{FUNC_WRITE, OFF_PAGE_SIZE, 32'h0,         3'd4, 1'b0, 32'd0},
    '{FUNC_WRITE, OFF_QSIZE,     32'hFFFF_FFFF, 3'd4, 1'b0, 32'd0},
    '{FUNC_WRITE, OFF_PAGE_SIZE, 32'hFFFF_FFFF, 3'd4, 1'b0, 32'd0},
    '{FUNC_WRITE, OFF_NOTIFY,    32'h0,         3'd4, 1'b0, 32'd0},
    '{FUNC_WRITE, OFF_STATUS,    32'hFFFF_FFFF, 3'd4, 1'b1, 32'd0},
    '{FUNC_READ,  OFF_STATUS,    32'h0,         3'd2, 1'b1, 32'hFFFF_FFFF},
    '{FUNC_RSVD,  OFF_STATUS,    32'hFFFF_FFFF, 3'd7, 1'b1, 32'd0},
    '{FUNC_READ,  9'h100,        32'h0,         3'd4, 1'b1, 32'h4433_2211},
    // size above four counts as four
    '{FUNC_READ,  9'h104,        32'h0,         3'd7, 1'b1, 32'h8877_6655},
    '{FUNC_READ,  9'h107,        32'h0,         3'd1, 1'b1, 32'h0000_0088},
    // runs past the end of config space
    '{FUNC_READ,  9'h105,        32'h0,         3'd4, 1'b1, 32'd0},
    '{FUNC_READ,  9'h100,        32'h0,         3'd0, 1'b1, 32'd0}
  };

  virtio_mmio_transport_registers dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Ring placement; skipped while queue size or page size is zero
  function automatic void place_rings();
    logic [63:0] base, dlen, alen, amask, uoff;
    if (q_size == 0 || page_sz == 0) return;
    base  = {32'b0, q_frame} * {32'b0, page_sz};
    dlen  = {32'b0, q_size} << 4;
    alen  = 64'd6 + ({32'b0, q_size} << 1);
    amask = {32'b0, q_align} - 64'd1;   // all ones while align is zero
    uoff  = (dlen + alen + amask) & ~amask;
    desc_addr  = base;
    avail_addr = base + dlen;
    used_addr  = base + uoff;
  endfunction

  // Applies one request to the model and returns the response it causes
  function automatic mmio_resp_t mmio_access(func_e kind, logic [8:0] off,
                                             logic [31:0] wd, logic [2:0] sz);
    mmio_resp_t  r;
    int unsigned n;
    int unsigned first;
    r     = '0;
    n     = (sz > 3'd4) ? 4 : int'(sz);
    first = int'(off) - int'(CFG_BEGIN);
    case (kind)
      FUNC_READ: begin
        case (off)
          OFF_MAGIC:     r.rdata = ID_MAGIC;
          OFF_VERSION:   r.rdata = 32'd1;
          OFF_DEVICE_ID: r.rdata = 32'd2;
          OFF_VENDOR_ID: r.rdata = ID_VENDOR;
          OFF_FEATURES:  r.rdata = 32'd0;
          OFF_QUEUE_MAX: r.rdata = 32'd256;
          OFF_ISR:       r.rdata = isr_bits;
          OFF_STATUS:    r.rdata = dev_status;
          default: begin
            // config space: little-endian capacity bytes
            if (off >= CFG_BEGIN && int'(off) + n <= int'(CFG_END)) begin
              for (int k = 0; k < n; k++)
                r.rdata[8*k +: 8] = cap_sectors[8*((first + k) % 8) +: 8];
            end
          end
        endcase
      end
      FUNC_WRITE: begin
        case (off)
          OFF_PAGE_SIZE: begin page_sz = wd; place_rings(); end
          OFF_QSIZE:     begin q_size = wd; place_rings(); end
          OFF_ALIGN:     begin q_align = (wd == 0) ? 32'd4096 : wd; place_rings(); end
          OFF_FRAME:     begin q_frame = wd; place_rings(); end
          OFF_NOTIFY:    r.kick = 1'b1;
          OFF_ACK:       isr_bits &= ~wd;
          OFF_STATUS:    dev_status = wd;
          default: ;
        endcase
      end
      FUNC_DONE: isr_bits |= 32'd1;
      default: ;
    endcase
    r.desc  = desc_addr;
    r.avail = avail_addr;
    r.used  = used_addr;
    r.qsize = q_size;
    r.irq   = (isr_bits != 0);
    return r;
  endfunction

  task automatic flag_mismatch(string fld, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s at cycle %0d: got %h, expected %h", fld, cyc_cnt, got, want);
    err_cnt++;
  endtask

  // Presents one request, waits for its handshake, logs what it should produce
  task automatic issue_request(func_e kind, logic [8:0] off, logic [31:0] wd,
                               logic [2:0] sz, bit known, logic [31:0] rd);
    mmio_resp_t exp_r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, sz, wd, off};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_r = mmio_access(kind, off, wd, sz);
    if (known) exp_r.rdata = rd;
    resp_due.push_back(exp_r);
  endtask

  // Sender holds off until every response is back
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (resp_due.size() != 0);
  endtask

  task automatic load_capacity(logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_sectors = v;
  endtask

  // Response side: random stall bursts, none in the calm tail
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    mmio_resp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rdata = m_axis_tdata[31:0];
      got.kick  = m_axis_tdata[32];
      got.desc  = m_axis_tdata[96:33];
      got.avail = m_axis_tdata[160:97];
      got.used  = m_axis_tdata[224:161];
      got.qsize = m_axis_tdata[256:225];
      got.irq   = m_axis_tdata[257];
      if (resp_due.size() == 0) begin
        flag_mismatch("unrequested response", m_axis_tdata[63:0], 64'h0);
      end else begin
        want = resp_due.pop_front();
        if (got.rdata !== want.rdata)
          flag_mismatch("rdata", 64'(got.rdata), 64'(want.rdata));
        if (got.kick  !== want.kick)
          flag_mismatch("kick", 64'(got.kick), 64'(want.kick));
        if (got.desc  !== want.desc)  flag_mismatch("desc_ring_addr", got.desc, want.desc);
        if (got.avail !== want.avail) flag_mismatch("avail_ring_addr", got.avail, want.avail);
        if (got.used  !== want.used)  flag_mismatch("used_ring_addr", got.used, want.used);
        if (got.qsize !== want.qsize)
          flag_mismatch("queue_size", 64'(got.qsize), 64'(want.qsize));
        if (got.irq   !== want.irq)
          flag_mismatch("irq_pending", 64'(got.irq), 64'(want.irq));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] cap;
    int          pick;
    func_e       kind;
    logic [8:0]  off;
    logic [31:0] wd;
    logic [2:0]  sz;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_READ;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    load_capacity(64'h8877_6655_4433_2211);
    for (int i = 0; i < N_DIR; i++)
      issue_request(dir_rows[i].kind, dir_rows[i].off, dir_rows[i].wd, dir_rows[i].sz,
                    dir_rows[i].known, dir_rows[i].rd);

    // random part, one capacity setting per phase
    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      case (ph)
        0:       cap = '1;
        1:       cap = '0;
        default: cap = {$urandom, $urandom};
      endcase
      load_capacity(cap);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        calm = (ph == 3) && (i >= PHASE_ITEMS - CALM_ITEMS);
        pick = $urandom_range(0, 99);
        if (pick < 45)      kind = FUNC_READ;
        else if (pick < 85) kind = FUNC_WRITE;
        else if (pick < 95) kind = FUNC_DONE;
        else                kind = FUNC_RSVD;
        // mostly mapped registers and config bytes, some anywhere
        pick = $urandom_range(0, 9);
        if (pick < 6)      off = hot_offs[$urandom_range(0, 13)];
        else if (pick < 8) off = CFG_BEGIN + 9'($urandom_range(0, 7));
        else               off = 9'($urandom_range(0, 511));
        // geometry wants small and power-of-two values as well as wide ones
        pick = $urandom_range(0, 9);
        if (pick == 0)     wd = '0;
        else if (pick == 1) wd = '1;
        else if (pick < 5) wd = 32'd1 << $urandom_range(0, 31);
        else if (pick < 7) wd = $urandom_range(1, 512);
        else               wd = $urandom;
        sz = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(1, 4));
        issue_request(kind, off, wd, sz, 1'b0, '0);
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
